[rtl/lspm_pkg.sv]
// ----------------------------------------------------------------------------
// Line segment projection package
// Widths, payload types and the segment classes shared by the projection
// front end, the job queue and the arithmetic back end.
// ----------------------------------------------------------------------------
package lspm_pkg;

    localparam int COORD_BITS = 32;
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int QW  = COORD_BITS + 2;
    localparam int OW  = QW + 1;
    localparam int LW  = NW / 2;
    localparam int HW  = NW - LW;
    localparam int MW  = DW + NW;
    localparam int DVW = MW + 2;
    localparam int DDW = NW + 1;
    localparam int RMW = DDW + 1;
    localparam int RW  = QW + 2;
    localparam int XW  = 2 * RW;
    localparam int FW  = COORD_BITS + 4;

    typedef enum logic [1:0] {
        SEG_GENERAL,
        SEG_FLAT,
        SEG_UPRIGHT
    } t_seg_class;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] foot_x;
        logic signed [COORD_BITS-1:0] foot_y;
        logic        [COORD_BITS-1:0] mileage;
        logic                         saturated;
    } t_out_item;

    typedef struct packed {
        t_seg_class                   cls;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [DW-1:0]         dx;
        logic signed [DW-1:0]         dy;
        logic signed [DW-1:0]         wx;
        logic signed [DW-1:0]         wy;
        logic        [NW-1:0]         nm_mag;
        logic                         nm_neg;
        logic        [NW-1:0]         den;
    } t_job;

    typedef struct packed {
        t_seg_class                   cls;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [DW-1:0]         wx;
        logic signed [DW-1:0]         wy;
        logic                         neg_x;
        logic                         neg_y;
    } t_side;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] foot_x;
        logic signed [COORD_BITS-1:0] foot_y;
        logic                         sat;
    } t_tail;

endpackage

[rtl/lspm_front.sv]
// ----------------------------------------------------------------------------
// Projection front end
// Accepts items, forms the difference vectors, classifies the segment and
// computes the dot product and squared length for the queue.
// ----------------------------------------------------------------------------
module lspm_front import lspm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_push,
    output t_job     o_job,
    input  logic     i_full
);

    logic w_en;

    logic                         r_v1, r_v2, r_v3;
    t_seg_class                   r1_cls, r2_cls;
    logic signed [COORD_BITS-1:0] r1_sx, r1_sy, r2_sx, r2_sy;
    logic signed [DW-1:0]         r1_dx, r1_dy, r1_wx, r1_wy;
    logic signed [DW-1:0]         r2_dx, r2_dy, r2_wx, r2_wy;
    logic signed [PW-1:0]         r2_p1, r2_p2, r2_q1, r2_q2;
    t_job                         r3_job;

    logic signed [DW-1:0]         w_dx, w_dy, w_wx, w_wy;
    t_seg_class                   w_cls;
    logic signed [NW-1:0]         w_nm;
    logic        [NW-1:0]         w_den;

    assign w_en    = !(r_v3 && i_full);
    assign o_stall = !w_en;
    assign o_push  = r_v3 && !i_full;
    assign o_job   = r3_job;

    always_comb begin
        w_dx = DW'(i_item.end_x) - DW'(i_item.start_x);
        w_dy = DW'(i_item.end_y) - DW'(i_item.start_y);
        w_wx = DW'(i_item.point_x) - DW'(i_item.start_x);
        w_wy = DW'(i_item.point_y) - DW'(i_item.start_y);
        if (w_dy == '0) begin
            w_cls = SEG_FLAT;
        end else if (w_dx == '0) begin
            w_cls = SEG_UPRIGHT;
        end else begin
            w_cls = SEG_GENERAL;
        end
        w_nm  = NW'(r2_p1) + NW'(r2_p2);
        w_den = NW'(unsigned'(r2_q1)) + NW'(unsigned'(r2_q2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cls <= w_cls;
            r1_sx  <= i_item.start_x;
            r1_sy  <= i_item.start_y;
            r1_dx  <= w_dx;
            r1_dy  <= w_dy;
            r1_wx  <= w_wx;
            r1_wy  <= w_wy;

            r2_cls <= r1_cls;
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_wx  <= r1_wx;
            r2_wy  <= r1_wy;
            r2_p1  <= r1_wx * r1_dx;
            r2_p2  <= r1_wy * r1_dy;
            r2_q1  <= r1_dx * r1_dx;
            r2_q2  <= r1_dy * r1_dy;

            r3_job.cls    <= r2_cls;
            r3_job.sx     <= r2_sx;
            r3_job.sy     <= r2_sy;
            r3_job.dx     <= r2_dx;
            r3_job.dy     <= r2_dy;
            r3_job.wx     <= r2_wx;
            r3_job.wy     <= r2_wy;
            r3_job.nm_neg <= w_nm[NW-1];
            r3_job.nm_mag <= w_nm[NW-1] ? NW'(-w_nm) : NW'(w_nm);
            r3_job.den    <= w_den;
        end
    end

endmodule

[rtl/lspm_fifo.sv]
// ----------------------------------------------------------------------------
// Projection job queue
// Small register queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module lspm_fifo import lspm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("Job pushed into a full queue.");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("Job popped from an empty queue.");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("Queue count beyond its depth.");
`endif

endmodule

[rtl/lspm_div.sv]
// ----------------------------------------------------------------------------
// Projection divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lspm_div import lspm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [DVW-1:0] i_num,
    input  logic [DDW-1:0] i_den,
    output logic [QW-1:0]  o_quo
);

    logic [RMW-1:0] s_rem [QW+1];
    logic [QW-1:0]  s_lo  [QW+1];
    logic [QW-1:0]  s_q   [QW+1];
    logic [DDW-1:0] s_d   [QW+1];

    assign s_rem[0] = RMW'(i_num[DVW-1:QW]);
    assign s_lo[0]  = i_num[QW-1:0];
    assign s_q[0]   = '0;
    assign s_d[0]   = i_den;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RMW-1:0] w_try;
        logic           w_ge;
        logic [RMW-1:0] r_rem;
        logic [QW-1:0]  r_lo;
        logic [QW-1:0]  r_q;
        logic [DDW-1:0] r_d;

        assign w_try = {s_rem[k][RMW-2:0], s_lo[k][QW-1]};
        assign w_ge  = (w_try >= RMW'(s_d[k]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? (w_try - RMW'(s_d[k])) : w_try;
                r_lo  <= {s_lo[k][QW-2:0], 1'b0};
                r_q   <= {s_q[k][QW-2:0], w_ge};
                r_d   <= s_d[k];
            end
        end

        assign s_rem[k+1] = r_rem;
        assign s_lo[k+1]  = r_lo;
        assign s_q[k+1]   = r_q;
        assign s_d[k+1]   = r_d;
    end

    assign o_quo = s_q[QW];

endmodule

[rtl/lspm_sqrt.sv]
// ----------------------------------------------------------------------------
// Projection square root
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lspm_sqrt import lspm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    output logic [RW-1:0] o_root
);

    logic [RW+1:0] s_rem  [RW+1];
    logic [RW-1:0] s_root [RW+1];
    logic [XW-1:0] s_x    [RW+1];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_x[0]    = i_x;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0] w_try;
        logic [RW+1:0] w_trial;
        logic          w_ge;
        logic [RW+1:0] r_rem;
        logic [RW-1:0] r_root;
        logic [XW-1:0] r_x;

        assign w_try   = {s_rem[k][RW-1:0], s_x[k][XW-1:XW-2]};
        assign w_trial = {s_root[k], 2'b01};
        assign w_ge    = (w_try >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? (w_try - w_trial) : w_try;
                r_root <= {s_root[k][RW-2:0], w_ge};
                r_x    <= {s_x[k][XW-3:0], 2'b00};
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_x[k+1]    = r_x;
    end

    assign o_root = s_root[RW];

endmodule

[rtl/lspm_back.sv]
// ----------------------------------------------------------------------------
// Projection back end
// Scales the dot product per axis, divides, forms the foot point with
// saturation and takes the rounded length of the offset.
// ----------------------------------------------------------------------------
module lspm_back import lspm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int VL = QW + RW + 5;
    localparam logic signed [FW-1:0] FMAX =
        {{(FW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [FW-1:0] FMIN =
        {{(FW - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

    logic            w_en;
    logic [VL-1:0]   r_vld;
    logic            r_out_valid;
    t_out_item       r_out;

    t_side             r1_side, r2_side;
    logic [DW+LW-1:0]  r1_lo_x, r1_lo_y;
    logic [DW+HW-1:0]  r1_hi_x, r1_hi_y;
    logic [NW-1:0]     r1_den;
    logic [DVW-1:0]    r2_n_x, r2_n_y;
    logic [DDW-1:0]    r2_d;
    t_side             r_sd [QW];

    logic [QW-1:0]     w_q_x, w_q_y;
    logic [DW-1:0]     w_dm_x, w_dm_y;
    logic [MW-1:0]     w_m_x, w_m_y;

    t_side             w_s3;
    logic signed [OW-1:0] w_ox, w_oy, w_qsx, w_qsy;
    logic signed [FW-1:0] w_fx, w_fy;
    t_tail             w_tail;
    logic [OW-1:0]     w_ax, w_ay;

    t_tail             r3_tail, r4_tail, r5_tail;
    logic [QW-1:0]     r3_mx, r3_my;
    logic [2*QW-1:0]   r4_sqx, r4_sqy;
    logic [XW-1:0]     r5_x;
    t_tail             r_td [RW];

    logic [RW-1:0]     w_root;
    logic [RW:0]       w_r1;
    logic [RW-1:0]     w_mil;
    logic              w_mil_sat;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_pop   = w_en && i_job_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        w_dm_x = i_job.dx[DW-1] ? DW'(-i_job.dx) : DW'(i_job.dx);
        w_dm_y = i_job.dy[DW-1] ? DW'(-i_job.dy) : DW'(i_job.dy);
        w_m_x  = (MW'(r1_hi_x) << LW) + MW'(r1_lo_x);
        w_m_y  = (MW'(r1_hi_y) << LW) + MW'(r1_lo_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[VL-2:0], o_pop};
            r_out_valid <= r_vld[VL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side.cls   <= i_job.cls;
            r1_side.sx    <= i_job.sx;
            r1_side.sy    <= i_job.sy;
            r1_side.wx    <= i_job.wx;
            r1_side.wy    <= i_job.wy;
            r1_side.neg_x <= i_job.dx[DW-1] ^ i_job.nm_neg;
            r1_side.neg_y <= i_job.dy[DW-1] ^ i_job.nm_neg;
            r1_lo_x <= w_dm_x * i_job.nm_mag[LW-1:0];
            r1_hi_x <= w_dm_x * i_job.nm_mag[NW-1:LW];
            r1_lo_y <= w_dm_y * i_job.nm_mag[LW-1:0];
            r1_hi_y <= w_dm_y * i_job.nm_mag[NW-1:LW];
            r1_den  <= i_job.den;

            r2_side <= r1_side;
            r2_n_x  <= {w_m_x, 1'b0} + DVW'(r1_den);
            r2_n_y  <= {w_m_y, 1'b0} + DVW'(r1_den);
            r2_d    <= {r1_den, 1'b0};

            r_sd[0] <= r2_side;
        end
    end

    for (genvar k = 1; k < QW; k++) begin : g_side_dly
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    lspm_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_n_x),
        .i_den (r2_d),
        .o_quo (w_q_x)
    );

    lspm_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_n_y),
        .i_den (r2_d),
        .o_quo (w_q_y)
    );

    always_comb begin
        w_s3  = r_sd[QW-1];
        w_qsx = signed'({1'b0, w_q_x});
        w_qsy = signed'({1'b0, w_q_y});
        unique case (w_s3.cls)
            SEG_FLAT: begin
                w_ox = OW'(w_s3.wx);
                w_oy = '0;
            end
            SEG_UPRIGHT: begin
                w_ox = '0;
                w_oy = OW'(w_s3.wy);
            end
            default: begin
                w_ox = w_s3.neg_x ? -w_qsx : w_qsx;
                w_oy = w_s3.neg_y ? -w_qsy : w_qsy;
            end
        endcase
        w_fx = FW'(w_s3.sx) + FW'(w_ox);
        w_fy = FW'(w_s3.sy) + FW'(w_oy);
        w_tail.sat = 1'b0;
        if (w_fx > FMAX) begin
            w_tail.foot_x = FMAX[COORD_BITS-1:0];
            w_tail.sat    = 1'b1;
        end else if (w_fx < FMIN) begin
            w_tail.foot_x = FMIN[COORD_BITS-1:0];
            w_tail.sat    = 1'b1;
        end else begin
            w_tail.foot_x = w_fx[COORD_BITS-1:0];
        end
        if (w_fy > FMAX) begin
            w_tail.foot_y = FMAX[COORD_BITS-1:0];
            w_tail.sat    = 1'b1;
        end else if (w_fy < FMIN) begin
            w_tail.foot_y = FMIN[COORD_BITS-1:0];
            w_tail.sat    = 1'b1;
        end else begin
            w_tail.foot_y = w_fy[COORD_BITS-1:0];
        end
        w_ax = w_ox[OW-1] ? OW'(-w_ox) : OW'(w_ox);
        w_ay = w_oy[OW-1] ? OW'(-w_oy) : OW'(w_oy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_tail <= w_tail;
            r3_mx   <= w_ax[QW-1:0];
            r3_my   <= w_ay[QW-1:0];

            r4_tail <= r3_tail;
            r4_sqx  <= r3_mx * r3_mx;
            r4_sqy  <= r3_my * r3_my;

            r5_tail <= r4_tail;
            r5_x    <= XW'({(2*QW+1)'(r4_sqx) + (2*QW+1)'(r4_sqy), 2'b00});

            r_td[0] <= r5_tail;
        end
    end

    for (genvar k = 1; k < RW; k++) begin : g_tail_dly
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_td[k] <= r_td[k-1];
            end
        end
    end

    lspm_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r5_x),
        .o_root (w_root)
    );

    always_comb begin
        w_r1      = (RW+1)'(w_root) + 1'b1;
        w_mil     = w_r1[RW:1];
        w_mil_sat = (w_mil[RW-1:COORD_BITS] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.foot_x    <= r_td[RW-1].foot_x;
            r_out.foot_y    <= r_td[RW-1].foot_y;
            r_out.mileage   <= w_mil_sat ? '1 : w_mil[COORD_BITS-1:0];
            r_out.saturated <= r_td[RW-1].sat | w_mil_sat;
        end
    end

endmodule

[rtl/line_segment_projection_mileage.sv]
// ----------------------------------------------------------------------------
// Line segment projection with mileage
// Projects a query point onto the line through a segment and returns the
// foot point and the distance from the segment start to it.
//
//   channel   direction   handshake              payload
//   input     in          i_valid / o_stall      i_item (t_in_item)
//   output    out         o_valid / i_stall      o_item (t_out_item)
//
// One transaction per clock is accepted and delivered when neither side
// stalls; the divider and square root pipelines resolve one bit per stage.
// Reset is synchronous and active low; it clears only the valid flags and
// the queue pointers and count.
// An output stall freezes the back end; the queue then fills and the
// front end raises o_stall.
// ----------------------------------------------------------------------------
module line_segment_projection_mileage import lspm_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic w_push, w_full, w_pop, w_empty;
    t_job w_job_in, w_job_out;

    lspm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_full  (w_full)
    );

    lspm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    lspm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

[tb/line_segment_projection_mileage_tb.sv]
// ----------------------------------------------------------------------------
// Line segment projection testbench
// Drives segments and query points through the projection block under random
// idling on both sides and checks every foot point, mileage and saturation
// flag against an exact wide-integer projection computed here.
// ----------------------------------------------------------------------------
module line_segment_projection_mileage_tb import lspm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] t_wide;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    t_in_item  pending_segments[$];
    t_out_item expected_feet[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      send_hold;
    int        mismatches;
    int        cycles;

    line_segment_projection_mileage dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_wide wide_abs(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_wide round_offset(t_wide dc, t_wide num, t_wide den);
        t_wide q;
        q = (2 * wide_abs(dc) * wide_abs(num) + den) / (2 * den);
        return ((dc < 0) != (num < 0)) ? -q : q;
    endfunction

    function automatic t_wide clamp_coord(t_wide v, ref logic sat);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -(t_wide'(1) <<< (COORD_BITS - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_out_item project_point(t_in_item it);
        t_wide     sx, sy, dx, dy, wx, wy, ox, oy, num, den, sq4, root, cand, mil, umax;
        t_wide     fx, fy;
        logic      sat;
        t_out_item r;
        sx = t_wide'(it.start_x);
        sy = t_wide'(it.start_y);
        dx = t_wide'(it.end_x) - sx;
        dy = t_wide'(it.end_y) - sy;
        wx = t_wide'(it.point_x) - sx;
        wy = t_wide'(it.point_y) - sy;
        if (dy == 0) begin
            ox = wx;
            oy = 0;
        end else if (dx == 0) begin
            ox = 0;
            oy = wy;
        end else begin
            num = wx * dx + wy * dy;
            den = dx * dx + dy * dy;
            ox = round_offset(dx, num, den);
            oy = round_offset(dy, num, den);
        end
        sat = 1'b0;
        fx = clamp_coord(sx + ox, sat);
        fy = clamp_coord(sy + oy, sat);
        r.foot_x = fx[COORD_BITS-1:0];
        r.foot_y = fy[COORD_BITS-1:0];
        sq4 = 4 * (ox * ox + oy * oy);
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (t_wide'(1) <<< b);
            if (cand * cand <= sq4) begin
                root = cand;
            end
        end
        mil = (root + 1) >>> 1;
        umax = (t_wide'(1) <<< COORD_BITS) - 1;
        if (mil > umax) begin
            mil = umax;
            sat = 1'b1;
        end
        r.mileage = mil[COORD_BITS-1:0];
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_feet.push_back(project_point(i_item));
            end
            if (!i_valid || !o_stall) begin
                if (send_hold || pending_segments.size() == 0
                        || $urandom_range(99) < send_idle_pct) begin
                    i_valid <= 1'b0;
                end else begin
                    i_item <= pending_segments.pop_front();
                    i_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_feet.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected transaction: %h", o_item);
                    end
                end else begin
                    want = expected_feet.pop_front();
                    if (o_item !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"Mismatch: foot (%h,%h) mileage %h sat %b, ",
                                      "expected (%h,%h) mileage %h sat %b"},
                                     o_item.foot_x, o_item.foot_y, o_item.mileage,
                                     o_item.saturated, want.foot_x, want.foot_y,
                                     want.mileage, want.saturated);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(65535)) - 32768);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                        : 32'h8000_0000 + $urandom_range(255);
            default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
        endcase
    endfunction

    function automatic t_in_item rand_segment();
        t_in_item it;
        it.start_x = rand_coord();
        it.start_y = rand_coord();
        it.end_x = rand_coord();
        it.end_y = rand_coord();
        it.point_x = rand_coord();
        it.point_y = rand_coord();
        case ($urandom_range(9))
            0: it.end_y = it.start_y;
            1: it.end_x = it.start_x;
            2: begin
                it.end_x = it.start_x;
                it.end_y = it.start_y;
            end
            3: begin
                it.end_x = it.start_x + $signed($urandom_range(8)) - 4;
                it.end_y = it.start_y + $signed($urandom_range(8)) - 4;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic add_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                               logic [31:0] ey, logic [31:0] px, logic [31:0] py);
        t_in_item it;
        it.start_x = sx;
        it.start_y = sy;
        it.end_x = ex;
        it.end_y = ey;
        it.point_x = px;
        it.point_y = py;
        pending_segments.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_segments.size() != 0 || i_valid || expected_feet.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_hold = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 46;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_segment(0, 0, 32'h0001_0000, 0, 32'h0003_0000, 32'h0005_0000);
        add_segment(0, 0, 0, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000);
        add_segment(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                    32'hFFFF_0000, 32'h0007_0000);
        add_segment(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0);
        add_segment(0, 0, 3, 1, 1, 0);
        add_segment(0, 0, 2, 2, 1, 0);
        add_segment(0, 0, 2, 2, 32'hFFFF_FFFF, 0);
        add_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000);
        add_segment(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_segment(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000);
        add_segment(0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001,
                    32'h8000_0000, 32'h7FFF_FFFF);
        add_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_segment(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'h0F0F_0F0F, 32'hF0F0_F0F0);
        wait_drained();

        send_hold = 1'b1;
        repeat (3) add_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord());
        repeat (20) @(posedge i_clk);
        send_hold = 1'b0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 33 : 0;
            repeat (500) pending_segments.push_back(rand_segment());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_feet.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
